/* sv/boost_time_limiter_assert.svh */
// ----------------------------------------------------------------------------
// Boost time limiter assertion macros
// Clocked assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BOOST_TIME_LIMITER_ASSERT_SVH
`define BOOST_TIME_LIMITER_ASSERT_SVH

// Assertion checked outside of reset.
`define BTL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assertion checked at every clock edge, reset included.
`define BTL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* sv/btl_pkg.sv */
// ----------------------------------------------------------------------------
// Boost time limiter package
// Widths, codes, reset values and shared types of the boost time limiter.
// ----------------------------------------------------------------------------
package btl_pkg;

  localparam int unsigned FREQ_W        = 22;
  localparam int unsigned LIM_W         = 16;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned IN_DATA_W     = 24;
  localparam int unsigned OUT_DATA_W    = 24;
  localparam int unsigned TIME_BITS_DEF = 16;
  localparam int unsigned RES_DEPTH     = 4;

  localparam logic [LIM_W-1:0] BOOST_LIMIT_RST = 16'd1000;
  localparam logic [LIM_W-1:0] REST_HOLD_RST   = 16'd100;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BOOST_FREQ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REST_FREQ   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REST_HOLD   = 2'd3;

  typedef enum logic [1:0] {
    CAUSE_REQUEST = 2'd0,
    CAUSE_CLAMP   = 2'd1,
    CAUSE_REST    = 2'd2,
    CAUSE_RESTORE = 2'd3
  } cause_e;

  typedef struct packed {
    logic [FREQ_W-1:0] applied_khz;
    logic              raise_voltage_first;
    logic              lower_voltage_after;
    cause_e            cause;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r1;
    result_t    r0;
  } step_t;

endpackage

/* sv/boost_time_limiter.sv */
// ----------------------------------------------------------------------------
// Boost time limiter
// Limits time spent at boost frequency by forcing a rest frequency period.
//
// Channel  Dir  Handshake                   Payload
// s_axis   in   s_axis_tvalid/tready        tdata requested_khz, tuser operation
// m_axis   out  m_axis_tvalid/tready        tdata applied_khz and voltage order,
//                                           tuser cause, tlast last
// cfg      in   cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// One request is accepted per cycle while s_axis_tready is high; it is
// registered, then processed combinationally into a four-entry result queue
// that offers it. A tick may give two results, written to the queue together.
// Input is taken while the input register is empty or the queue has room for
// two results; output stalls back up into the input register. Reset clears the
// control state and loads the register defaults; the configuration port is always ready.
// ----------------------------------------------------------------------------
module boost_time_limiter #(
  parameter int unsigned TIME_BITS = btl_pkg::TIME_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [21:0] requested_khz, [23:22] zero
  input  logic [btl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] operation
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [21:0] applied_khz, [22] raise_voltage_first, [23] lower_voltage_after
  output logic [btl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [1:0] cause
  output logic [1:0]                         m_axis_tuser,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [btl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [btl_pkg::FREQ_W-1:0]         cfg_data_i
);

  logic                       in_valid_q, in_valid_d;
  logic                       in_op_q;
  logic [btl_pkg::FREQ_W-1:0] in_khz_q;
  logic                       go, space;
  btl_pkg::step_t             step;
  btl_pkg::result_t           res;

  assign cfg_ready_o   = 1'b1;
  assign go            = in_valid_q && space;
  assign s_axis_tready = !in_valid_q || space;
  assign in_valid_d    = s_axis_tvalid ? 1'b1 : (in_valid_q && !space);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q  <= s_axis_tuser[0];
      in_khz_q <= s_axis_tdata[btl_pkg::FREQ_W-1:0];
    end
  end

  btl_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .go_i        (go),
    .op_i        (in_op_q),
    .khz_i       (in_khz_q),
    .step_o      (step)
  );

  btl_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {res.lower_voltage_after, res.raise_voltage_first, res.applied_khz};
  assign m_axis_tuser = res.cause;
  assign m_axis_tlast = res.last;

endmodule

/* sv/btl_core.sv */
// ----------------------------------------------------------------------------
// Boost time limiter core
// Configuration, limiter state and the per-item update that yields results.
// ----------------------------------------------------------------------------
module btl_core #(
  parameter int unsigned TIME_BITS = btl_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [btl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [btl_pkg::FREQ_W-1:0]     cfg_data_i,
  input  logic                           go_i,
  input  logic                           op_i,
  input  logic [btl_pkg::FREQ_W-1:0]     khz_i,
  output btl_pkg::step_t                 step_o
);

  localparam int unsigned FW = btl_pkg::FREQ_W;
  localparam int unsigned LW = btl_pkg::LIM_W;
  localparam int unsigned CW = (TIME_BITS > LW) ? TIME_BITS : LW;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0] TIME_ONE = TIME_BITS'(1);

  logic [FW-1:0]        boost_freq_q, rest_freq_q;
  logic [LW-1:0]        boost_limit_q, rest_hold_q;

  logic [FW-1:0]        applied_q, applied_d;
  logic [FW-1:0]        target_q, target_d;
  logic                 monitor_q, monitor_d;
  logic                 bt_active_q, bt_active_d;
  logic [TIME_BITS-1:0] bt_count_q, bt_count_d;
  logic                 resting_q, resting_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic                 rt_active_q, rt_active_d;
  logic [TIME_BITS-1:0] rt_count_q, rt_count_d;

  logic [CW-1:0]        limit_ext, hold_ext;
  logic [TIME_BITS-1:0] limit_t, hold_t;
  logic                 boost_fire, restore_fire, has_a, has_b;
  logic [FW-1:0]        cur;
  btl_pkg::result_t     res_a, res_b;

  function automatic btl_pkg::result_t make_res(logic [FW-1:0] f, logic [FW-1:0] prev,
                                               btl_pkg::cause_e cause, logic last);
    btl_pkg::result_t r;
    r.applied_khz         = f;
    r.raise_voltage_first = (f > prev);
    r.lower_voltage_after = (f < prev);
    r.cause               = cause;
    r.last                = last;
    return r;
  endfunction

  assign limit_ext = CW'(boost_limit_q);
  assign hold_ext  = CW'(rest_hold_q);
  assign limit_t   = limit_ext[TIME_BITS-1:0];
  assign hold_t    = hold_ext[TIME_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boost_freq_q  <= '0;
      boost_limit_q <= btl_pkg::BOOST_LIMIT_RST;
      rest_freq_q   <= '0;
      rest_hold_q   <= btl_pkg::REST_HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        btl_pkg::REG_BOOST_FREQ:  boost_freq_q  <= cfg_data_i;
        btl_pkg::REG_BOOST_LIMIT: boost_limit_q <= cfg_data_i[LW-1:0];
        btl_pkg::REG_REST_FREQ:   rest_freq_q   <= cfg_data_i;
        btl_pkg::REG_REST_HOLD:   rest_hold_q   <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    applied_d    = applied_q;
    target_d     = target_q;
    monitor_d    = monitor_q;
    bt_active_d  = bt_active_q;
    bt_count_d   = bt_count_q;
    resting_d    = resting_q;
    elapsed_d    = elapsed_q;
    rt_active_d  = rt_active_q;
    rt_count_d   = rt_count_q;
    boost_fire   = 1'b0;
    restore_fire = 1'b0;
    has_a        = 1'b0;
    has_b        = 1'b0;
    cur          = applied_q;
    res_a        = '0;
    res_b        = '0;
    step_o       = '0;
    if (go_i) begin
      if (op_i == btl_pkg::OP_REQUEST) begin
        if (khz_i != '0 && khz_i != applied_q) begin
          target_d = khz_i;
          if (resting_q && khz_i > rest_freq_q && hold_ext > CW'(elapsed_q)) begin
            step_o.r0    = make_res(rest_freq_q, applied_q, btl_pkg::CAUSE_CLAMP, 1'b1);
            step_o.count = 2'd1;
            applied_d    = rest_freq_q;
          end else begin
            if (resting_q && khz_i > rest_freq_q) begin
              resting_d = 1'b0;
              elapsed_d = '0;
            end
            if (boost_freq_q != '0 && monitor_q && khz_i < boost_freq_q) begin
              monitor_d   = 1'b0;
              bt_active_d = 1'b0;
            end
            if (boost_freq_q != '0 && !monitor_d && khz_i >= boost_freq_q) begin
              monitor_d   = 1'b1;
              bt_active_d = 1'b1;
              bt_count_d  = limit_t;
            end
            step_o.r0    = make_res(khz_i, applied_q, btl_pkg::CAUSE_REQUEST, 1'b1);
            step_o.count = 2'd1;
            applied_d    = khz_i;
          end
        end
      end else begin
        if (resting_q && elapsed_q != TIME_MAX) begin
          elapsed_d = elapsed_q + TIME_ONE;
        end
        if (bt_active_q) begin
          if (bt_count_q != '0) begin
            bt_count_d = bt_count_q - TIME_ONE;
          end
          boost_fire = (bt_count_d == '0);
        end
        if (rt_active_q) begin
          if (rt_count_q != '0) begin
            rt_count_d = rt_count_q - TIME_ONE;
          end
          restore_fire = (rt_count_d == '0);
        end
        if (restore_fire) begin
          rt_active_d = 1'b0;
          resting_d   = 1'b0;
          elapsed_d   = '0;
          if (target_q > rest_freq_q && boost_freq_q != '0) begin
            bt_active_d = 1'b1;
            bt_count_d  = limit_t;
          end
          if (target_q != '0) begin
            res_a = make_res(target_q, cur, btl_pkg::CAUSE_RESTORE, 1'b0);
            cur   = target_q;
            has_a = 1'b1;
          end
        end
        if (boost_fire) begin
          bt_active_d = 1'b0;
          resting_d   = 1'b1;
          elapsed_d   = '0;
          rt_active_d = 1'b1;
          rt_count_d  = hold_t;
          if (rest_freq_q != '0) begin
            res_b = make_res(rest_freq_q, cur, btl_pkg::CAUSE_REST, 1'b0);
            cur   = rest_freq_q;
            has_b = 1'b1;
          end
        end
        applied_d = cur;
        if (has_a) begin
          step_o.r0 = res_a;
          step_o.r1 = res_b;
          if (has_b) begin
            step_o.count   = 2'd2;
            step_o.r1.last = 1'b1;
          end else begin
            step_o.count   = 2'd1;
            step_o.r0.last = 1'b1;
          end
        end else if (has_b) begin
          step_o.r0      = res_b;
          step_o.r0.last = 1'b1;
          step_o.count   = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      applied_q   <= '0;
      target_q    <= '0;
      monitor_q   <= 1'b0;
      bt_active_q <= 1'b0;
      bt_count_q  <= '0;
      resting_q   <= 1'b0;
      elapsed_q   <= '0;
      rt_active_q <= 1'b0;
      rt_count_q  <= '0;
    end else begin
      applied_q   <= applied_d;
      target_q    <= target_d;
      monitor_q   <= monitor_d;
      bt_active_q <= bt_active_d;
      bt_count_q  <= bt_count_d;
      resting_q   <= resting_d;
      elapsed_q   <= elapsed_d;
      rt_active_q <= rt_active_d;
      rt_count_q  <= rt_count_d;
    end
  end

endmodule

/* sv/btl_res_fifo.sv */
// ----------------------------------------------------------------------------
// Boost time limiter result queue
// Small queue that takes up to two results per cycle and hands out one while ready_i is high.
// ----------------------------------------------------------------------------
module btl_res_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  btl_pkg::step_t   step_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output btl_pkg::result_t res_o
);

  localparam int unsigned DEPTH = btl_pkg::RES_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CNTW  = $clog2(DEPTH + 1);

  btl_pkg::result_t mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  count_q, count_d;
  logic             pop;

  assign pop      = valid_o && ready_i;
  assign valid_o  = (count_q != '0);
  assign space_o  = (count_q <= CNTW'(DEPTH - 2));
  assign res_o    = mem_q[rd_ptr_q];
  assign wr_ptr_d = wr_ptr_q + PW'(step_i.count);
  assign rd_ptr_d = rd_ptr_q + PW'(pop);
  assign count_d  = count_q + CNTW'(step_i.count) - CNTW'(pop);

  always_ff @(posedge clk_i) begin
    if (step_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= step_i.r0;
    end
    if (step_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PW'(1)] <= step_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* sv/btl_checker.sv */
// ----------------------------------------------------------------------------
// Boost time limiter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "boost_time_limiter_assert.svh"

module btl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [btl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                     m_axis_tuser,
  input logic                           m_axis_tlast
);

  logic                             raise, lower, req_cause, held;
  logic [btl_pkg::OUT_DATA_W+2:0]   word;

  assign raise     = m_axis_tdata[btl_pkg::FREQ_W];
  assign lower     = m_axis_tdata[btl_pkg::FREQ_W+1];
  assign req_cause = (m_axis_tuser == btl_pkg::CAUSE_REQUEST) ||
                     (m_axis_tuser == btl_pkg::CAUSE_CLAMP);
  assign held      = m_axis_tvalid && !m_axis_tready;
  assign word      = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  `BTL_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !m_axis_tvalid, "result during reset")

  `BTL_ASSERT(a_voltage_order, m_axis_tvalid |-> !(raise && lower), "both voltage flags set")

  `BTL_ASSERT(a_request_is_last, m_axis_tvalid && req_cause |-> m_axis_tlast, "request not last")

  `BTL_ASSERT(a_result_holds, held |=> m_axis_tvalid && $stable(word), "stalled result changed")

endmodule

bind boost_time_limiter btl_checker u_btl_checker (.*);
